>>> hdl/fpdow_pkg.sv
package fpdow_pkg;

  localparam int ErrW   = 24;
  localparam int ScaleW = 24;
  localparam int CmdW   = 8;
  localparam int SpdW   = 18;
  localparam int NormW  = 16;
  localparam int CfgIdxW = 3;

  localparam logic signed [NormW-1:0] OneQ14 = 16'sd16384;
  localparam logic [15:0] Span = 16'h8000;

  localparam logic signed [24:0] KX  = 25'sd5221384;
  localparam logic signed [24:0] KYH = 25'sd2621440;
  localparam logic signed [24:0] KY  = 25'sd5242880;
  localparam logic signed [24:0] KW  = 25'sd5235330;

  localparam logic signed [15:0] RS = 16'sd5456;
  localparam logic signed [15:0] RM = 16'sd10912;
  localparam logic signed [15:0] RB = 16'sd16384;

  localparam logic signed [15:0] RULE_TAB [7][7] = '{
    '{-RS, -RM, -RB, -RB, -RB, -RM, -RS},
    '{-RS, -RS, -RM, -RM, -RM, -RS, -RS},
    '{-RS, -RS, -RM, -RS, -RM, -RS, -RS},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{RS, RS, RM, RS, RM, RS, RS},
    '{RS, RS, RM, RM, RM, RS, RS},
    '{RS, RM, RB, RB, RB, RM, RS}
  };

  typedef enum logic [CmdW-1:0] {
    CMD_TRACK  = 8'd0,
    CMD_STOP   = 8'd1,
    CMD_LEFT   = 8'd10,
    CMD_RIGHT  = 8'd11,
    CMD_BACK   = 8'd12
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_ERR  = 3'd0,
    REG_Y_ERR  = 3'd1,
    REG_H_ERR  = 3'd2,
    REG_X_RATE = 3'd3,
    REG_Y_RATE = 3'd4,
    REG_H_RATE = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_FUZ, L_ACC, L_DONE
  } lane_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_RUN, T_MIX, T_SUM, T_EMIT
  } top_state_t;

endpackage

>>> hdl/fpdow_if.sv
interface fpdow_pose_if import fpdow_pkg::*; ();
  logic valid;
  logic ready;
  logic [CmdW-1:0] command;
  logic signed [ErrW-1:0] x_error;
  logic signed [ErrW-1:0] y_error;
  logic signed [ErrW-1:0] heading_error;
  modport source(output valid, command, x_error, y_error, heading_error, input ready);
  modport sink(input valid, command, x_error, y_error, heading_error, output ready);
endinterface

interface fpdow_wheel_if import fpdow_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SpdW-1:0] wheel_a_speed;
  logic signed [SpdW-1:0] wheel_b_speed;
  logic signed [SpdW-1:0] wheel_c_speed;
  logic elevation_flag;
  modport source(output valid, wheel_a_speed, wheel_b_speed, wheel_c_speed,
                 elevation_flag, input ready);
  modport sink(input valid, wheel_a_speed, wheel_b_speed, wheel_c_speed,
               elevation_flag, output ready);
endinterface

>>> hdl/fpdow_lane.sv
module fpdow_lane import fpdow_pkg::*; #(
  parameter int Levels = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [ErrW-1:0] err,
  input  logic signed [ErrW-1:0] prev,
  input  logic [ScaleW-1:0] err_scale,
  input  logic [ScaleW-1:0] rate_scale,
  output logic done,
  output logic signed [NormW-1:0] u
);

  localparam int IW = $clog2(Levels);
  localparam int UW = 16 + $clog2(Levels);
  localparam int KW = UW - 15;

  lane_state_t state, state_next;

  logic signed [ErrW-1:0] e_r;
  logic signed [ErrW:0]   d_r;
  logic zero_r;
  logic signed [49:0] pe, pd;
  logic [IW-1:0] ke, kr;
  logic [15:0] fe, fr;
  logic [1:0] term;
  logic phase;
  logic [30:0] wprod;
  logic signed [46:0] acc;

  logic [2:0] map_tab [Levels];

  for (genvar g = 0; g < Levels; g++) begin : g_map
    localparam int M0 = (g * 12 + Levels - 1) / (2 * (Levels - 1));
    localparam int M  = (M0 > 6) ? 6 : M0;
    assign map_tab[g] = 3'(M);
  end

  function automatic logic signed [NormW-1:0] nrm(logic signed [49:0] p);
    logic signed [49:0] r;
    r = (p + 50'sd8192) >>> 14;
    if (r > 50'sd16384) r = 50'sd16384;
    if (r < -50'sd16384) r = -50'sd16384;
    return NormW'(r);
  endfunction

  function automatic logic [IW+15:0] fuzz(logic signed [NormW-1:0] e);
    logic [15:0] sh;
    logic [UW-1:0] uu;
    logic [KW-1:0] k;
    logic [15:0] f;
    sh = 16'(e + OneQ14);
    uu = UW'(sh) * UW'(Levels - 1);
    k = uu[UW-1:15];
    f = {1'b0, uu[14:0]};
    if (k >= KW'(Levels - 1)) begin
      k = KW'(Levels - 2);
      f = Span;
    end
    return {IW'(k), f};
  endfunction

  logic [IW+15:0] fz_e, fz_r;
  logic [IW-1:0] ie, ir;
  logic [16:0] wa, wb;
  logic signed [15:0] rule;
  logic signed [47:0] rprod;
  logic signed [46:0] rnd;

  always_comb begin
    fz_e = fuzz(nrm(pe));
    fz_r = fuzz(nrm(pd));
    ie = IW'(ke + IW'(term[1]));
    ir = IW'(kr + IW'(term[0]));
    wa = term[1] ? {1'b0, fe} : 17'(Span - fe);
    wb = term[0] ? {1'b0, fr} : 17'(Span - fr);
    rule = RULE_TAB[map_tab[ie]][map_tab[ir]];
    rprod = rule * $signed({1'b0, wprod});
    rnd = (acc + 47'sd536870912) >>> 30;
  end

  always_comb begin
    state_next = state;
    case (state)
      L_IDLE: if (start) state_next = L_MUL;
      L_MUL:  state_next = L_FUZ;
      L_FUZ:  state_next = L_ACC;
      L_ACC:  if (term == 2'd3 && phase) state_next = L_DONE;
      L_DONE: state_next = L_IDLE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    done = (state == L_DONE);
    u = zero_r ? '0 : NormW'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        e_r <= err;
        d_r <= (ErrW+1)'(prev) - (ErrW+1)'(err);
        zero_r <= (err == '0);
      end
      L_MUL: begin
        pe <= 50'(e_r * $signed({1'b0, err_scale}));
        pd <= 50'(d_r * $signed({1'b0, rate_scale}));
      end
      L_FUZ: begin
        ke <= fz_e[IW+15:16];
        fe <= fz_e[15:0];
        kr <= fz_r[IW+15:16];
        fr <= fz_r[15:0];
        acc <= '0;
        term <= '0;
        phase <= 1'b0;
      end
      L_ACC: begin
        if (!phase) begin
          wprod <= 31'(wa * wb);
        end else begin
          acc <= acc + 47'(rprod);
          term <= term + 2'd1;
        end
        phase <= ~phase;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/fuzzy_pd_omni_wheel_controller.sv
// Fuzzy PD wheel controller for a three-wheel omni base. A tracking item
// (command 0) runs x, y and heading through three identical fuzzy lanes side
// by side, then a mixing stage turns the three axis outputs into wheel speeds;
// each lane sums four rule terms, forming each term's weight product and then
// adding its weighted rule. Stop, rotate and back commands give their fixed
// speeds without the lanes; other commands give no result. One item is worked
// at a time; the next item may be accepted while a result still waits at the
// output. The user must write registers through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this.
module fuzzy_pd_omni_wheel_controller import fpdow_pkg::*; #(
  parameter int RULE_LEVELS = 7
) (
  input  logic clk,
  input  logic rst,
  fpdow_pose_if.sink pose,
  fpdow_wheel_if.source wheels,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ScaleW-1:0] cfg_data
);

  top_state_t state, state_next;

  logic [ScaleW-1:0] x_err_scale, y_err_scale, h_err_scale;
  logic [ScaleW-1:0] x_rate_scale, y_rate_scale, h_rate_scale;
  logic signed [ErrW-1:0] prev_x, prev_y, prev_h;
  logic elevation_held;

  logic accept, is_track, is_fixed, start, load_out;
  logic done_x, done_y, done_h;
  logic signed [NormW-1:0] ux, uy, uw;
  logic signed [40:0] px, pyh, py, pw;
  logic signed [SpdW-1:0] res_a, res_b, res_c;
  logic signed [41:0] sa, sb, sc;

  fpdow_lane #(.Levels(RULE_LEVELS)) u_lane_x (
    .clk, .rst, .start, .err(pose.x_error), .prev(prev_x),
    .err_scale(x_err_scale), .rate_scale(x_rate_scale), .done(done_x), .u(ux)
  );
  fpdow_lane #(.Levels(RULE_LEVELS)) u_lane_y (
    .clk, .rst, .start, .err(pose.y_error), .prev(prev_y),
    .err_scale(y_err_scale), .rate_scale(y_rate_scale), .done(done_y), .u(uy)
  );
  fpdow_lane #(.Levels(RULE_LEVELS)) u_lane_h (
    .clk, .rst, .start, .err(pose.heading_error), .prev(prev_h),
    .err_scale(h_err_scale), .rate_scale(h_rate_scale), .done(done_h), .u(uw)
  );

  always_comb begin
    is_track = (pose.command == CMD_TRACK);
    is_fixed = (pose.command == CMD_STOP) || (pose.command == CMD_LEFT) ||
               (pose.command == CMD_RIGHT) || (pose.command == CMD_BACK);
    sa = -42'(px) + 42'(pyh) + 42'(pw);
    sb = -42'(py) + 42'(pw);
    sc = 42'(px) + 42'(pyh) + 42'(pw);
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (accept && is_track) state_next = T_RUN;
        else if (accept && is_fixed) state_next = T_EMIT;
      end
      T_RUN:  if (done_x) state_next = T_MIX;
      T_MIX:  state_next = T_SUM;
      T_SUM:  state_next = T_EMIT;
      T_EMIT: if (load_out) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    pose.ready = (state == T_IDLE);
    accept = pose.valid && pose.ready;
    start = accept && is_track;
    load_out = (state == T_EMIT) && (!wheels.valid || wheels.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      wheels.valid <= 1'b0;
      elevation_held <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      prev_h <= '0;
      x_err_scale <= 24'd32768;
      y_err_scale <= 24'd32768;
      h_err_scale <= 24'd504;
      x_rate_scale <= 24'd142469;
      y_rate_scale <= 24'd163840;
      h_rate_scale <= 24'd25206;
    end else begin
      state <= state_next;
      if (load_out) wheels.valid <= 1'b1;
      else if (wheels.ready) wheels.valid <= 1'b0;
      if (start) begin
        prev_x <= pose.x_error;
        prev_y <= pose.y_error;
        prev_h <= pose.heading_error;
      end
      if (accept && pose.command == CMD_STOP) elevation_held <= 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          REG_X_ERR:  x_err_scale <= cfg_data;
          REG_Y_ERR:  y_err_scale <= cfg_data;
          REG_H_ERR:  h_err_scale <= cfg_data;
          REG_X_RATE: x_rate_scale <= cfg_data;
          REG_Y_RATE: y_rate_scale <= cfg_data;
          REG_H_RATE: h_rate_scale <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (pose.command)
        CMD_STOP:  begin res_a <= 18'sd0;   res_b <= 18'sd0;   res_c <= 18'sd0;   end
        CMD_LEFT:  begin res_a <= 18'sd256; res_b <= 18'sd256; res_c <= 18'sd256; end
        CMD_RIGHT: begin res_a <= -18'sd256; res_b <= -18'sd256; res_c <= -18'sd256; end
        CMD_BACK:  begin res_a <= 18'sd512; res_b <= 18'sd0;   res_c <= -18'sd512; end
        default: ;
      endcase
    end
    if (state == T_MIX) begin
      px  <= ux * KX;
      pyh <= uy * KYH;
      py  <= uy * KY;
      pw  <= uw * KW;
    end
    if (state == T_SUM) begin
      res_a <= SpdW'((sa + 42'sd2097152) >>> 22);
      res_b <= SpdW'((sb + 42'sd2097152) >>> 22);
      res_c <= SpdW'((sc + 42'sd2097152) >>> 22);
    end
    if (load_out) begin
      wheels.wheel_a_speed <= res_a;
      wheels.wheel_b_speed <= res_b;
      wheels.wheel_c_speed <= res_c;
      wheels.elevation_flag <= elevation_held;
    end
  end

`ifndef SYNTH
  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    (done_x == done_y) && (done_x == done_h))
    else $error("lanes out of step");
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    done_x |-> state == T_RUN)
    else $error("lane finished outside run");
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(wheels.valid) |-> $past(state) == T_EMIT)
    else $error("result without emit");
`endif

endmodule
